@@ design/nat_ipv4_header_rewrite_core_macros.svh @@
// assertion macros for the nat header rewrite core
// no dependencies; included by modules that carry concurrent checks
`ifndef NAT_IPV4_HEADER_REWRITE_CORE_MACROS_SVH
`define NAT_IPV4_HEADER_REWRITE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// check an implication on every rising clock edge outside reset
`define NATR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("natr assertion failed");
// check that a condition never holds outside reset
`define NATR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("natr assertion failed");
`else
`define NATR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NATR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/natr_pkg.sv @@
// types, status codes and checksum helpers for the nat header rewrite core
// no dependencies; used by natr_decode and nat_ipv4_header_rewrite_core
package natr_pkg;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_HDR = 2'd1;
    localparam logic [1:0] ST_NO_TCP = 2'd2;

    // mode flag bit positions
    localparam int FLAG_IPSRC = 0;
    localparam int FLAG_IPDST = 1;
    localparam int FLAG_L4SRC = 2;
    localparam int FLAG_L4DST = 3;
    localparam int FLAG_SEQ   = 4;
    localparam int FLAG_ACK   = 5;
    localparam int FLAG_CSUM  = 6;

    // number of register stages from accept to result strobe
    localparam int LATENCY = 5;

    typedef struct packed {
        logic [6:0]  mode_flags;
        logic        headers_found;
        logic        is_tcp;
        logic [63:0] old_addresses;
        logic [63:0] new_addresses;
        logic [31:0] old_ports;
        logic [31:0] new_ports;
        logic [63:0] old_seq_ack;
        logic [31:0] seq_ack_deltas;
        logic [31:0] old_checksums;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_addresses;
        logic [31:0] out_ports;
        logic [63:0] out_seq_ack;
        logic [15:0] out_ip_checksum;
        logic [15:0] out_l4_checksum;
    } t_result;

    // per-item rewrite enables, decided once at entry
    typedef struct packed {
        logic src;
        logic dst;
        logic port;
        logic seq;
        logic ack;
        logic csm;
    } t_en;

    // data carried between pipeline stages
    typedef struct packed {
        logic [1:0]  status;
        t_en         en;
        logic [63:0] addr;
        logic [31:0] old_dst;
        logic [31:0] ports;
        logic [31:0] old_ports;
        logic [63:0] seq_ack;
        logic [63:0] old_seq_ack;
        logic [15:0] ip_ck;
        logic [15:0] l4_ck;
    } t_pipe;

    // incremental ones' complement checksum update for one 32-bit word
    function automatic logic [15:0] csum_adjust(input logic [15:0] sum,
                                                input logic [31:0] oldw,
                                                input logic [31:0] neww);
        logic [18:0] acc;
        logic [16:0] f1;
        logic [16:0] f2;
        acc = {3'd0, ~sum} + {3'd0, ~oldw[31:16]} + {3'd0, ~oldw[15:0]}
            + {3'd0, neww[31:16]} + {3'd0, neww[15:0]};
        f1 = {1'b0, acc[15:0]} + {14'd0, acc[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return ~f2[15:0];
    endfunction

    // add a sign-extended 16-bit delta modulo 2^32
    function automatic logic [31:0] add_delta(input logic [31:0] v,
                                              input logic [15:0] d);
        return v + {{16{d[15]}}, d};
    endfunction

endpackage

@@ design/natr_decode.sv @@
// entry stage: decodes the mode flags, picks new fields, adds deltas
// and applies the source address checksum update; depends on natr_pkg
module natr_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  natr_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    output natr_pkg::t_pipe o_stage
);
    import natr_pkg::*;

    logic  r_valid;
    t_pipe r_stage;
    t_pipe n_stage;
    t_en   en;
    logic  seq_ack_req;

    // rewrite enables, all gated by the header check except the checksum enable csm
    always_comb begin
        en.src  = i_cmd.headers_found & i_cmd.mode_flags[FLAG_IPSRC];
        en.dst  = i_cmd.headers_found & i_cmd.mode_flags[FLAG_IPDST];
        en.port = i_cmd.headers_found
                & (i_cmd.mode_flags[FLAG_L4SRC] | i_cmd.mode_flags[FLAG_L4DST]);
        en.seq  = i_cmd.headers_found & i_cmd.is_tcp & i_cmd.mode_flags[FLAG_SEQ];
        en.ack  = i_cmd.headers_found & i_cmd.is_tcp & i_cmd.mode_flags[FLAG_ACK];
        en.csm  = i_cmd.mode_flags[FLAG_CSUM];
        seq_ack_req = i_cmd.mode_flags[FLAG_SEQ] | i_cmd.mode_flags[FLAG_ACK];
    end

    // new field values and first checksum step
    always_comb begin
        n_stage.en          = en;
        n_stage.old_dst     = i_cmd.old_addresses[31:0];
        n_stage.old_ports   = i_cmd.old_ports;
        n_stage.old_seq_ack = i_cmd.old_seq_ack;

        priority if (!i_cmd.headers_found) begin
            n_stage.status = ST_NO_HDR;
        end else if (seq_ack_req && !i_cmd.is_tcp) begin
            n_stage.status = ST_NO_TCP;
        end else begin
            n_stage.status = ST_OK;
        end

        n_stage.addr[63:32] = en.src ? i_cmd.new_addresses[63:32]
                                     : i_cmd.old_addresses[63:32];
        n_stage.addr[31:0]  = en.dst ? i_cmd.new_addresses[31:0]
                                     : i_cmd.old_addresses[31:0];

        n_stage.ports[31:16] = (en.port && i_cmd.mode_flags[FLAG_L4SRC])
                             ? i_cmd.new_ports[31:16] : i_cmd.old_ports[31:16];
        n_stage.ports[15:0]  = (en.port && i_cmd.mode_flags[FLAG_L4DST])
                             ? i_cmd.new_ports[15:0] : i_cmd.old_ports[15:0];

        n_stage.seq_ack[63:32] = en.seq
            ? add_delta(i_cmd.old_seq_ack[63:32], i_cmd.seq_ack_deltas[31:16])
            : i_cmd.old_seq_ack[63:32];
        n_stage.seq_ack[31:0]  = en.ack
            ? add_delta(i_cmd.old_seq_ack[31:0], i_cmd.seq_ack_deltas[15:0])
            : i_cmd.old_seq_ack[31:0];

        n_stage.ip_ck = en.src
            ? csum_adjust(i_cmd.old_checksums[31:16], i_cmd.old_addresses[63:32],
                          i_cmd.new_addresses[63:32])
            : i_cmd.old_checksums[31:16];
        n_stage.l4_ck = (en.src && en.csm)
            ? csum_adjust(i_cmd.old_checksums[15:0], i_cmd.old_addresses[63:32],
                          i_cmd.new_addresses[63:32])
            : i_cmd.old_checksums[15:0];
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

@@ design/nat_ipv4_header_rewrite_core.sv @@
// nat ipv4 header rewrite core: five-stage pipeline, one header per cycle
// result strobe o_done follows the start transfer through the decode register and stages 2 to 5
// throughput: one transfer per cycle, busy stays low; one l4 checksum word per stage
// the receiver cannot stall; results are shown for exactly one cycle
// reset: synchronous active-low i_rst_n clears all stage valid bits
// depends on natr_pkg, natr_decode and the macros header
`include "nat_ipv4_header_rewrite_core_macros.svh"
module nat_ipv4_header_rewrite_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  natr_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_done,
    output natr_pkg::t_result o_result
);
    import natr_pkg::*;

    logic  s1_valid;
    t_pipe s1;
    logic  r_v2, r_v3, r_v4, r_v5;
    t_pipe r_s2, r_s3, r_s4, r_s5;
    t_pipe n_s2, n_s3, n_s4, n_s5;

    // entry stage
    natr_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_cmd   (i_cmd),
        .o_valid (s1_valid),
        .o_stage (s1)
    );

    // stage 2: destination address on the ip checksum, and on the l4 checksum when csm is set
    always_comb begin
        n_s2 = s1;
        if (s1.en.dst) begin
            n_s2.ip_ck = csum_adjust(s1.ip_ck, s1.old_dst, s1.addr[31:0]);
        end
        if (s1.en.dst && s1.en.csm) begin
            n_s2.l4_ck = csum_adjust(s1.l4_ck, s1.old_dst, s1.addr[31:0]);
        end
    end

    // stage 3: port word on the l4 checksum
    always_comb begin
        n_s3 = r_s2;
        if (r_s2.en.port && r_s2.en.csm) begin
            n_s3.l4_ck = csum_adjust(r_s2.l4_ck, r_s2.old_ports, r_s2.ports);
        end
    end

    // stage 4: sequence number on the l4 checksum
    always_comb begin
        n_s4 = r_s3;
        if (r_s3.en.seq && r_s3.en.csm) begin
            n_s4.l4_ck = csum_adjust(r_s3.l4_ck, r_s3.old_seq_ack[63:32],
                                     r_s3.seq_ack[63:32]);
        end
    end

    // stage 5: acknowledgement number on the l4 checksum
    always_comb begin
        n_s5 = r_s4;
        if (r_s4.en.ack && r_s4.en.csm) begin
            n_s5.l4_ck = csum_adjust(r_s4.l4_ck, r_s4.old_seq_ack[31:0],
                                     r_s4.seq_ack[31:0]);
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v2 <= s1_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
        r_s3 <= n_s3;
        r_s4 <= n_s4;
        r_s5 <= n_s5;
    end

    // result
    assign busy   = 1'b0;
    assign o_done = r_v5;
    always_comb begin
        o_result.status          = r_s5.status;
        o_result.out_addresses   = r_s5.addr;
        o_result.out_ports       = r_s5.ports;
        o_result.out_seq_ack     = r_s5.seq_ack;
        o_result.out_ip_checksum = r_s5.ip_ck;
        o_result.out_l4_checksum = r_s5.l4_ck;
    end

    // checks
    `NATR_ASSERT_IMPL(a_latency, i_clk, i_rst_n, start && !busy, ##5 o_done)
    `NATR_ASSERT_IMPL(a_nohdr_pass, i_clk, i_rst_n, o_done && o_result.status == ST_NO_HDR, o_result.out_addresses == $past(i_cmd.old_addresses, 5))
    `NATR_ASSERT_IMPL(a_notcp_ack, i_clk, i_rst_n, o_done && o_result.status == ST_NO_TCP, o_result.out_seq_ack[31:0] == $past(i_cmd.old_seq_ack[31:0], 5))
    `NATR_ASSERT_NEVER(a_bad_status, i_clk, i_rst_n, o_done && o_result.status != ST_OK && o_result.status != ST_NO_HDR && o_result.status != ST_NO_TCP)

endmodule
